### design/alt_pkg.sv
// types and constants shared by the assembly line tokenizer modules
// no dependencies

package alt_pkg;

   // result kinds
   localparam logic [1:0] KIND_TOKEN = 2'd0;
   localparam logic [1:0] KIND_LINE_DONE = 2'd1;
   localparam logic [1:0] KIND_STRING_ERROR = 2'd2;

   // characters the scanner reacts to
   localparam logic [7:0] CH_EOL = 8'h00;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_SEMI = 8'h3B;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;

   typedef struct packed {
      logic [7:0] ch;
      logic       new_file;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  start_pos;
      logic [7:0]  end_pos;
      logic [15:0] line_number;
      logic [7:0]  token_count;
      logic        last;
   } rsp_type;

   // what one item leaves for the back end: one or two results
   typedef struct packed {
      rsp_type first;
      rsp_type second;
      logic    two;
   } pair_type;

endpackage

### design/assembly_line_tokenizer_core.sv
// assembly line tokenizer: one character item in, token and line reports out
// ports: req_push/req_full/req_item in, rsp_empty/rsp_pop/rsp_item out
// depends on alt_pkg, alt_front, alt_queue, alt_back
//
// Input is a queue-like channel: an item (one character plus new_file) is
// taken at a clock edge with req_push high and req_full low. Byte 0 ends a
// line. Each item gives zero, one or two results; results leave through the
// rsp channel, the oldest shown while rsp_empty is low and taken on rsp_pop.
// The front end classifies one character per cycle while the queue has room
// and writes the results of an item as one entry into a four-entry queue;
// the back end hands out one result per cycle from its output register while
// the receiver pops, so two-result items (a comma after a token, a line end
// inside a token) leave one after the other; the output side sets the
// sustained rate. The first result of an item is written to the queue at the
// edge that takes it and then loaded into the output register.
// When the receiver stalls the queue fills and req_full rises; nothing is
// lost. Synchronous reset clears the queue and output register and puts the
// scanner in search mode with line number 1. An unterminated string halts
// the scanner, which then drops items until one arrives with new_file set.

module assembly_line_tokenizer_core #(
   parameter int MAX_LINE = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  alt_pkg::req_type req_item,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output alt_pkg::rsp_type rsp_item
);

   logic              accept;
   logic              f_push;
   alt_pkg::pair_type f_entry;
   logic              q_empty;
   logic              q_pop;
   alt_pkg::pair_type q_head;

   assign accept = req_push && !req_full;

   alt_front #(
      .MAX_LINE(MAX_LINE)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .req_item(req_item),
      .push(f_push),
      .entry(f_entry)
   );

   alt_queue #(
      .DEPTH(4)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(f_push),
      .push_data(f_entry),
      .full(req_full),
      .pop(q_pop),
      .empty(q_empty),
      .head(q_head)
   );

   alt_back u_back (
      .clock(clock),
      .reset(reset),
      .q_empty(q_empty),
      .q_head(q_head),
      .q_pop(q_pop),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_item(rsp_item)
   );

endmodule

### design/alt_front.sv
// front end: scanner state and classification of each character item
// depends on alt_pkg

module alt_front #(
   parameter int MAX_LINE = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  alt_pkg::req_type  req_item,
   output logic              push,
   output alt_pkg::pair_type entry
);

   localparam int PosCap = ((MAX_LINE - 1) > 255) ? 255 : (MAX_LINE - 1);
   localparam logic [7:0] PosCapW = 8'(PosCap);

   typedef enum logic [1:0] {
      SEARCH,
      GRAB,
      QUOTE,
      IGNORE
   } mode_type;

   mode_type    mode_ff, mode_in, mode_e;
   logic [7:0]  pos_ff, pos_in, pos_e;
   logic [7:0]  begin_ff, begin_in, begin_e;
   logic        bs_ff, bs_in, bs_e;
   logic [7:0]  tok_ff, tok_in, tok_e;
   logic [15:0] line_ff, line_in, line_e;
   logic        halt_ff, halt_in, halt_e;

   logic [7:0]  ch;
   logic        blank;
   logic        eol;
   logic [1:0]  n;
   logic [7:0]  end_before;
   logic [7:0]  tok1, tok2;
   alt_pkg::rsp_type r0, r1;

   always_comb begin
      ch = req_item.ch;
      blank = (ch == alt_pkg::CH_SPACE) || (ch == alt_pkg::CH_TAB);

      // a new file starts a fresh line and clears the halt
      mode_e = req_item.new_file ? SEARCH : mode_ff;
      pos_e = req_item.new_file ? 8'd0 : pos_ff;
      begin_e = req_item.new_file ? 8'd0 : begin_ff;
      bs_e = req_item.new_file ? 1'b0 : bs_ff;
      tok_e = req_item.new_file ? 8'd0 : tok_ff;
      line_e = req_item.new_file ? 16'd1 : line_ff;
      halt_e = req_item.new_file ? 1'b0 : halt_ff;

      mode_in = mode_e;
      pos_in = pos_e;
      begin_in = begin_e;
      bs_in = bs_e;
      tok_in = tok_e;
      line_in = line_e;
      halt_in = halt_e;

      end_before = (pos_e > begin_e) ? pos_e - 8'd1 : begin_e;
      tok1 = (tok_e == 8'hFF) ? tok_e : tok_e + 8'd1;
      tok2 = (tok1 == 8'hFF) ? tok1 : tok1 + 8'd1;

      r0 = '{kind: alt_pkg::KIND_TOKEN, start_pos: begin_e, end_pos: end_before,
             line_number: line_e, token_count: tok1, last: 1'b0};
      r1 = '{kind: alt_pkg::KIND_LINE_DONE, start_pos: 8'd0, end_pos: 8'd0,
             line_number: line_e, token_count: tok1, last: 1'b0};
      n = 2'd0;
      eol = 1'b0;

      if (!halt_e) begin
         case (mode_e)
            SEARCH: begin
               if (ch == alt_pkg::CH_EOL) begin
                  eol = 1'b1;
                  r0.kind = alt_pkg::KIND_LINE_DONE;
                  r0.start_pos = 8'd0;
                  r0.end_pos = 8'd0;
                  r0.token_count = tok_e;
                  n = 2'd1;
               end else if (blank) begin
                  mode_in = SEARCH;
               end else if (ch == alt_pkg::CH_QUOTE) begin
                  begin_in = pos_e;
                  mode_in = QUOTE;
               end else if (ch == alt_pkg::CH_SEMI) begin
                  mode_in = IGNORE;
               end else begin
                  begin_in = pos_e;
                  mode_in = GRAB;
               end
            end
            GRAB: begin
               if (ch == alt_pkg::CH_EOL || blank) begin
                  tok_in = tok1;
                  mode_in = SEARCH;
                  n = 2'd1;
                  if (ch == alt_pkg::CH_EOL) begin
                     eol = 1'b1;
                     n = 2'd2;
                  end
               end else if (ch == alt_pkg::CH_COMMA) begin
                  // closed token, then the comma as a token of its own
                  r1.kind = alt_pkg::KIND_TOKEN;
                  r1.start_pos = pos_e;
                  r1.end_pos = pos_e;
                  r1.token_count = tok2;
                  tok_in = tok2;
                  mode_in = SEARCH;
                  n = 2'd2;
               end else if (ch == alt_pkg::CH_SEMI) begin
                  tok_in = tok1;
                  mode_in = IGNORE;
                  n = 2'd1;
               end
            end
            QUOTE: begin
               if (blank) begin
                  tok_in = tok1;
                  mode_in = SEARCH;
                  n = 2'd1;
               end else if (ch == alt_pkg::CH_QUOTE) begin
                  if (!bs_e) begin
                     r0.end_pos = pos_e;
                     tok_in = tok1;
                     mode_in = SEARCH;
                     n = 2'd1;
                  end
               end else if (ch == alt_pkg::CH_EOL) begin
                  r0.kind = alt_pkg::KIND_STRING_ERROR;
                  r0.end_pos = pos_e;
                  r0.token_count = tok_e;
                  halt_in = 1'b1;
                  n = 2'd1;
               end
            end
            default: begin
               if (ch == alt_pkg::CH_EOL) begin
                  eol = 1'b1;
                  r0.kind = alt_pkg::KIND_LINE_DONE;
                  r0.start_pos = 8'd0;
                  r0.end_pos = 8'd0;
                  r0.token_count = tok_e;
                  n = 2'd1;
               end
            end
         endcase

         if (eol) begin
            line_in = (line_e == 16'hFFFF) ? line_e : line_e + 16'd1;
            mode_in = SEARCH;
            pos_in = 8'd0;
            begin_in = 8'd0;
            bs_in = 1'b0;
            tok_in = 8'd0;
         end else if (!halt_in) begin
            pos_in = (pos_e < PosCapW) ? pos_e + 8'd1 : PosCapW;
            bs_in = (ch == alt_pkg::CH_BACKSLASH);
         end
      end

      if (n == 2'd2) begin
         r1.last = 1'b1;
      end else begin
         r0.last = 1'b1;
      end

      push = accept && (n != 2'd0);
      entry.first = r0;
      entry.second = r1;
      entry.two = (n == 2'd2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= SEARCH;
         pos_ff <= 8'd0;
         begin_ff <= 8'd0;
         bs_ff <= 1'b0;
         tok_ff <= 8'd0;
         line_ff <= 16'd1;
         halt_ff <= 1'b0;
      end else if (accept) begin
         mode_ff <= mode_in;
         pos_ff <= pos_in;
         begin_ff <= begin_in;
         bs_ff <= bs_in;
         tok_ff <= tok_in;
         line_ff <= line_in;
         halt_ff <= halt_in;
      end
   end

endmodule

### design/alt_queue.sv
// short queue of result pairs between front and back end
// depends on alt_pkg

module alt_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  alt_pkg::pair_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output alt_pkg::pair_type head
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] DepthW = CntW'(DEPTH);

   alt_pkg::pair_type slot_ff [DEPTH];
   logic [PtrW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic do_push, do_pop;

   always_comb begin
      full = (cnt_ff == DepthW);
      empty = (cnt_ff == '0);
      head = slot_ff[rd_ff];
      do_push = push && !full;
      do_pop = pop && !empty;
      wr_in = do_push ? ((wr_ff == LastPtr) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in = do_pop ? ((rd_ff == LastPtr) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

### design/alt_back.sv
// back end: splits result pairs into single items and holds the output register
// depends on alt_pkg

module alt_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  alt_pkg::pair_type q_head,
   output logic              q_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output alt_pkg::rsp_type  rsp_item
);

   logic             valid_ff, valid_in;
   logic             second_ff, second_in;
   alt_pkg::rsp_type out_ff, out_in;
   logic             load;

   always_comb begin
      // output register takes a new item when it is empty or being drained
      load = (!valid_ff || rsp_pop) && !q_empty;
      valid_in = valid_ff && !rsp_pop;
      second_in = second_ff;
      out_in = out_ff;
      q_pop = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         if (second_ff) begin
            out_in = q_head.second;
            second_in = 1'b0;
            q_pop = 1'b1;
         end else begin
            out_in = q_head.first;
            if (q_head.two) begin
               second_in = 1'b1;
            end else begin
               q_pop = 1'b1;
            end
         end
      end
      rsp_empty = !valid_ff;
      rsp_item = out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

endmodule
